FILE: hdl/bbrmq_pkg.sv
// ----------------------------------------------------------------------------
// bbrmq_pkg
// Shared types, codes and helpers of the block range-minimum query unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bbrmq_pkg;

  localparam int BLOCK_LEN = 31;

  typedef logic [BLOCK_LEN-1:0] win_mask_t;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_BUILD  = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_RANGE = 2'd2,
    ST_NOT_BUILT = 2'd3
  } status_t;

  function automatic logic [4:0] top_bit(input win_mask_t m);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < BLOCK_LEN; i++) begin
      if (m[i]) begin
        n = 5'(i);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/bitmask_block_range_min_query_unit.sv
// ----------------------------------------------------------------------------
// bitmask_block_range_min_query_unit
// Range-minimum engine: append, sparse-table build, range query, clear.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-----------------------------------
//   in      | in  | in_valid/in_stall  | cmd, value, range_first, range_end
//   out     | out | out_valid/out_stall| min_pos, status
//
// One command at a time; the input stalls until its result is registered.
// Append: up to 30 value compares, one value read per compare. Build: one
// mask read and table write per full block, then two table reads and two
// value reads per upper entry, level by level. Query: mask, table and value
// reads. Clear, store full and a rejected query go straight to the result.
// Reset clears count, running mask and the built flag; memories need none.
// A waiting result does not block the next transfer on the input.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmask_block_range_min_query_unit #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int VALUE_BITS   = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire bbrmq_pkg::cmd_t               cmd,
  input  wire logic signed [VALUE_BITS-1:0]  value,
  input  wire logic [9:0]                    range_first,
  input  wire logic [10:0]                   range_end,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [9:0]                         min_pos,
  output bbrmq_pkg::status_t                 status
);
  import bbrmq_pkg::*;

  localparam int IW     = $clog2(MAX_ELEMENTS);
  localparam int CW     = IW + 1;
  localparam int NB     = MAX_ELEMENTS / BLOCK_LEN;
  localparam int NBW    = $clog2(NB + 1);
  localparam int LEVELS = $clog2(NB + 1);
  localparam int LW     = $clog2(LEVELS + 1);
  localparam int TDEPTH = LEVELS * NB;
  localparam int TAW    = $clog2(TDEPTH);
  localparam int DS     = CW + 5;
  localparam int DK     = (2 ** DS) / BLOCK_LEN;

  typedef logic signed [VALUE_BITS-1:0] val_t;

  typedef enum logic [4:0] {
    S_IDLE, S_APP_RD, S_APP_CMP,
    S_B0_RD, S_B0_WR, S_BLVL, S_BJCHK, S_BRA, S_BRB, S_BVA, S_BVB, S_BWR,
    S_QMRD, S_QMSK, S_QMV, S_QTCHK, S_QTRD, S_QTIX, S_QTV,
    S_RESULT
  } state_t;

  function automatic logic [CW-1:0] div_blk(input logic [CW-1:0] x);
    logic [CW+DS-1:0] p;
    logic [CW-1:0]    q;
    logic [CW-1:0]    rem;
    p   = (CW+DS)'(x) * (CW+DS)'(DK);
    q   = p[CW+DS-1:DS];
    rem = x - CW'(q * CW'(BLOCK_LEN));
    if (rem >= CW'(BLOCK_LEN)) begin
      q = q + 1'b1;
    end
    return q;
  endfunction

  function automatic logic [TAW-1:0] tab_addr(input logic [LW-1:0] lvl,
                                              input logic [NBW:0] blk);
    logic [31:0] a;
    a = 32'(int'(lvl) * NB) + 32'(blk);
    return a[TAW-1:0];
  endfunction

  function automatic logic [LW-1:0] top_nb(input logic [NBW-1:0] x);
    logic [LW-1:0] n;
    n = '0;
    for (int i = 0; i < NBW; i++) begin
      if (x[i]) begin
        n = LW'(i);
      end
    end
    return n;
  endfunction

  val_t          val_mem [MAX_ELEMENTS];
  win_mask_t     msk_mem [MAX_ELEMENTS];
  logic [IW-1:0] tab_mem [TDEPTH];

  val_t          val_rdata;
  win_mask_t     msk_rdata;
  logic [IW-1:0] tab_rdata;
  logic [IW-1:0] val_raddr, msk_raddr;
  logic [TAW-1:0] tab_raddr;
  logic          msk_we, tab_we;
  logic [TAW-1:0] tab_waddr;
  logic [IW-1:0] tab_wdata;

  state_t        state;
  logic [CW-1:0] count;
  win_mask_t     running;
  logic          built;
  logic [IW-1:0] res_idx;
  status_t       res_status;
  logic [IW-1:0] out_idx;

  win_mask_t     am;
  logic [IW-1:0] ai;
  val_t          av;
  logic          astop;

  logic [NBW-1:0] nb, t;
  logic [CW-1:0]  baddr;
  logic [NBW:0]   pw;
  logic [LW-1:0]  k;
  logic [NBW-1:0] j;
  logic [IW-1:0]  ta, tb;
  val_t           va;

  logic [IW-1:0]  ql, qr, qlast, cand, best_idx;
  logic [4:0]     qlen;
  logic           qshort, msel, tsel, best_vld;
  val_t           best_val;
  logic [NBW-1:0] xq, yq;
  logic [LW-1:0]  dep;

  logic           accept;
  logic [31:0]    first32, end32;
  win_mask_t      a_low, q_masked;
  logic [IW-1:0]  a_j, q_last_sel, q_w;
  logic           cand_wins;
  logic [IW-1:0]  mg_idx;
  val_t           mg_val;
  logic [IW-1:0]  bsel;
  logic [NBW+1:0] jend;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign first32  = 32'(range_first);
  assign end32    = 32'(range_end);

  assign a_low = am & (~am + 1'b1);
  assign a_j   = ai - IW'(top_bit(a_low));

  assign q_last_sel = (msel || qshort) ? qr : ql + IW'(BLOCK_LEN - 1);
  assign q_masked   = msk_rdata &
                      ((qshort && !msel) ? ((win_mask_t'(1) << qlen) - 1'b1) : '1);
  assign q_w        = (q_masked == '0) ? qlast : qlast - IW'(top_bit(q_masked));

  assign cand_wins = !best_vld || (val_rdata < best_val) ||
                     ((val_rdata == best_val) && (cand < best_idx));
  assign mg_idx    = cand_wins ? cand : best_idx;
  assign mg_val    = cand_wins ? val_rdata : best_val;

  assign bsel = ((val_rdata < va) || ((val_rdata == va) && (tb < ta))) ? tb : ta;
  assign jend = (NBW+2)'(j) + (NBW+2)'({pw, 1'b0});

  always_comb begin
    val_raddr = ai;
    msk_raddr = baddr[IW-1:0];
    tab_raddr = '0;
    unique case (state)
      S_APP_RD: val_raddr = a_j;
      S_BRA:    tab_raddr = tab_addr(k - 1'b1, (NBW+1)'(j));
      S_BRB:    tab_raddr = tab_addr(k - 1'b1, (NBW+1)'(j) + pw);
      S_BVA:    val_raddr = ta;
      S_BVB:    val_raddr = tb;
      S_QMRD:   msk_raddr = q_last_sel;
      S_QMSK:   val_raddr = q_w;
      S_QTRD:   tab_raddr = tsel ?
                  tab_addr(dep, (NBW+1)'(yq) - ((NBW+1)'(1) << dep)) :
                  tab_addr(dep, (NBW+1)'(xq));
      S_QTIX:   val_raddr = tab_rdata;
      default: ;
    endcase
  end

  assign msk_we    = (state == S_APP_RD) && ((am == '0) || astop);
  assign tab_we    = (state == S_B0_WR) || (state == S_BWR);
  assign tab_waddr = (state == S_B0_WR) ? tab_addr('0, (NBW+1)'(t)) :
                                          tab_addr(k, (NBW+1)'(j));
  assign tab_wdata = (state == S_B0_WR) ?
                     baddr[IW-1:0] - IW'(top_bit(msk_rdata)) : bsel;

  always_ff @(posedge clk) begin
    if (accept && (cmd == CMD_APPEND) && (count < CW'(MAX_ELEMENTS))) begin
      val_mem[count[IW-1:0]] <= value;
    end
    val_rdata <= val_mem[val_raddr];
  end

  always_ff @(posedge clk) begin
    if (msk_we) begin
      msk_mem[ai] <= am | win_mask_t'(1);
    end
    msk_rdata <= msk_mem[msk_raddr];
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    tab_rdata <= tab_mem[tab_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      running   <= '0;
      built     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          res_idx    <= '0;
          res_status <= ST_OK;
          if (accept) begin
            unique case (cmd)
              CMD_APPEND: begin
                if (count < CW'(MAX_ELEMENTS)) begin
                  av    <= value;
                  ai    <= count[IW-1:0];
                  am    <= {running[BLOCK_LEN-2:0], 1'b0};
                  astop <= 1'b0;
                  state <= S_APP_RD;
                end else begin
                  res_status <= ST_FULL;
                  state      <= S_RESULT;
                end
              end
              CMD_BUILD: begin
                nb    <= NBW'(div_blk(count));
                t     <= '0;
                baddr <= CW'(BLOCK_LEN - 1);
                state <= S_B0_RD;
              end
              CMD_QUERY: begin
                if ((first32 >= end32) || (end32 > 32'(count))) begin
                  res_status <= ST_BAD_RANGE;
                  state      <= S_RESULT;
                end else if (!built) begin
                  res_status <= ST_NOT_BUILT;
                  state      <= S_RESULT;
                end else begin
                  ql       <= IW'(first32);
                  qr       <= IW'(end32 - 32'd1);
                  qlen     <= 5'(end32 - first32);
                  qshort   <= (end32 - first32) <= 32'(BLOCK_LEN);
                  xq       <= NBW'(div_blk(CW'(first32)) + 1'b1);
                  yq       <= NBW'(div_blk(CW'(end32 - 32'd1)));
                  msel     <= 1'b0;
                  best_vld <= 1'b0;
                  state    <= S_QMRD;
                end
              end
              CMD_CLEAR: begin
                count   <= '0;
                running <= '0;
                built   <= 1'b0;
                state   <= S_RESULT;
              end
            endcase
          end
        end
        S_APP_RD: begin
          if ((am == '0) || astop) begin
            running <= am | win_mask_t'(1);
            count   <= count + 1'b1;
            built   <= 1'b0;
            state   <= S_RESULT;
          end else begin
            state <= S_APP_CMP;
          end
        end
        S_APP_CMP: begin
          if (val_rdata <= av) begin
            astop <= 1'b1;
          end else begin
            am <= am ^ a_low;
          end
          state <= S_APP_RD;
        end
        S_B0_RD: begin
          if (t == nb) begin
            pw    <= (NBW+1)'(1);
            k     <= LW'(1);
            state <= S_BLVL;
          end else begin
            state <= S_B0_WR;
          end
        end
        S_B0_WR: begin
          t     <= t + 1'b1;
          baddr <= baddr + CW'(BLOCK_LEN);
          state <= S_B0_RD;
        end
        S_BLVL: begin
          if (((NBW+2)'({pw, 1'b0}) <= (NBW+2)'(nb)) && (k < LW'(LEVELS))) begin
            j     <= '0;
            state <= S_BJCHK;
          end else begin
            built <= 1'b1;
            state <= S_RESULT;
          end
        end
        S_BJCHK: begin
          if (jend <= (NBW+2)'(nb)) begin
            state <= S_BRA;
          end else begin
            pw    <= {pw[NBW-1:0], 1'b0};
            k     <= k + 1'b1;
            state <= S_BLVL;
          end
        end
        S_BRA: state <= S_BRB;
        S_BRB: begin
          ta    <= tab_rdata;
          state <= S_BVA;
        end
        S_BVA: begin
          tb    <= tab_rdata;
          state <= S_BVB;
        end
        S_BVB: begin
          va    <= val_rdata;
          state <= S_BWR;
        end
        S_BWR: begin
          j     <= j + 1'b1;
          state <= S_BJCHK;
        end
        S_QMRD: begin
          qlast <= q_last_sel;
          state <= S_QMSK;
        end
        S_QMSK: begin
          if (qshort) begin
            res_idx <= q_w;
            state   <= S_RESULT;
          end else begin
            cand  <= q_w;
            state <= S_QMV;
          end
        end
        S_QMV: begin
          best_idx <= mg_idx;
          best_val <= mg_val;
          best_vld <= 1'b1;
          if (!msel) begin
            msel  <= 1'b1;
            state <= S_QMRD;
          end else begin
            state <= S_QTCHK;
          end
        end
        S_QTCHK: begin
          if (xq < yq) begin
            dep   <= top_nb(yq - xq);
            tsel  <= 1'b0;
            state <= S_QTRD;
          end else begin
            res_idx <= best_idx;
            state   <= S_RESULT;
          end
        end
        S_QTRD: state <= S_QTIX;
        S_QTIX: begin
          cand  <= tab_rdata;
          state <= S_QTV;
        end
        S_QTV: begin
          best_idx <= mg_idx;
          best_val <= mg_val;
          if (!tsel) begin
            tsel  <= 1'b1;
            state <= S_QTRD;
          end else begin
            res_idx <= mg_idx;
            state   <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!out_valid || !out_stall) begin
            out_idx   <= res_idx;
            status    <= res_status;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic [IW+9:0] out_idx_ext;
  assign out_idx_ext = (IW+10)'(out_idx);
  assign min_pos     = out_idx_ext[9:0];

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ELEMENTS))
    else $error("element count beyond store depth");

  a_running_live: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> running[0])
    else $error("running mask lost its newest entry");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("transfer accepted without starting work");

  a_out_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RESULT))
    else $error("result shown without a finished command");

endmodule

`default_nettype wire

FILE: tb/tb_bitmask_block_range_min_query_unit.sv
// ----------------------------------------------------------------------------
// tb_bitmask_block_range_min_query_unit
// Self-checking bench: directed commands with expected results, then random
// clear/append/build/query traffic checked by a range-minimum predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_bitmask_block_range_min_query_unit;
  import bbrmq_pkg::*;

  localparam int MAXN   = 1024;
  localparam int NBLK   = MAXN / BLOCK_LEN;
  localparam int LEVELS = 17;
  localparam logic [9:0] NO_IDX = 10'd0;

  typedef struct packed {
    cmd_t               op;
    logic signed [31:0] val;
    logic [9:0]         lo;
    logic [10:0]        hi;
    logic               known;
    logic [9:0]         idx;
    status_t            st;
  } row_t;

  typedef struct packed {
    logic [9:0] idx;
    status_t    st;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  cmd_t cmd = CMD_CLEAR;
  logic signed [31:0] value = '0;
  logic [9:0] range_first = '0;
  logic [10:0] range_end = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [9:0] min_pos;
  status_t status;

  bitmask_block_range_min_query_unit u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .value(value), .range_first(range_first), .range_end(range_end),
    .out_valid(out_valid), .out_stall(out_stall), .min_pos(min_pos),
    .status(status)
  );

  always #10 clk = ~clk;

  logic signed [31:0] vals[MAXN];
  win_mask_t masks[MAXN];
  win_mask_t run_mask;
  int count;
  logic built;
  int sparse[LEVELS][NBLK];
  answer_t pending[$];
  int mismatches = 0;
  int stall_left = 0;
  bit sender_done = 0;

  function automatic int msb(int x);
    int n;
    n = 0;
    while (x > 1) begin
      x = x >> 1;
      n++;
    end
    return n;
  endfunction

  function automatic int lesser(int a, int b);
    if (vals[a] < vals[b]) return a;
    if (vals[b] < vals[a]) return b;
    return a < b ? a : b;
  endfunction

  function automatic int suffix_min(int last, int len);
    int m;
    m = masks[last] & ((1 << len) - 1);
    if (m == 0) return last;
    return last - msb(m);
  endfunction

  function automatic answer_t predict(cmd_t op, logic signed [31:0] v,
                                      int lo, int hi);
    answer_t a;
    int m, low, r, x, y, dep, best, nb, pw, k;
    a.idx = NO_IDX;
    a.st = ST_OK;
    case (op)
      CMD_APPEND: begin
        if (count >= MAXN) begin
          a.st = ST_FULL;
        end else begin
          vals[count] = v;
          m = (run_mask << 1) & 32'h7fff_ffff;
          while (m != 0) begin
            low = m & -m;
            if (lesser(count, count - msb(low)) != count) break;
            m = m ^ low;
          end
          m = m | 1;
          run_mask = m;
          masks[count] = m;
          count++;
          built = 1'b0;
        end
      end
      CMD_BUILD: begin
        nb = count / BLOCK_LEN;
        for (int t = 0; t < nb; t++) sparse[0][t] = suffix_min(BLOCK_LEN * t + 30, 31);
        pw = 1;
        k = 1;
        while (pw * 2 <= nb && k < LEVELS) begin
          for (int j = 0; j + 2 * pw <= nb; j++)
            sparse[k][j] = lesser(sparse[k-1][j], sparse[k-1][j+pw]);
          pw *= 2;
          k++;
        end
        built = 1'b1;
      end
      CMD_QUERY: begin
        if (lo >= hi || hi > count) a.st = ST_BAD_RANGE;
        else if (!built) a.st = ST_NOT_BUILT;
        else begin
          r = hi - 1;
          if (r - lo + 1 <= BLOCK_LEN) best = suffix_min(r, r - lo + 1);
          else begin
            best = lesser(suffix_min(lo + 30, 31), suffix_min(r, 31));
            x = lo / BLOCK_LEN + 1;
            y = r / BLOCK_LEN;
            if (x < y) begin
              dep = msb(y - x);
              best = lesser(best, lesser(sparse[dep][x], sparse[dep][y - (1 << dep)]));
            end
          end
          a.idx = best[9:0];
        end
      end
      default: begin
        count = 0;
        run_mask = '0;
        built = 1'b0;
      end
    endcase
    return a;
  endfunction

  function automatic int gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  task automatic transfer(cmd_t op, logic signed [31:0] v, logic [9:0] lo,
                          logic [10:0] hi, bit known = 1'b0, answer_t exp = '0);
    answer_t a;
    int n;
    cmd <= op;
    value <= v;
    range_first <= lo;
    range_end <= hi;
    in_valid <= 1'b1;
    a = predict(op, v, lo, hi);
    if (known) a = exp;
    pending.push_back(a);
    do @(posedge clk); while (in_stall);
    n = gap();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending.size() == 0);
    @(posedge clk);
  endtask

  task automatic random_query();
    int lo, hi;
    if (count == 0 || $urandom_range(0, 9) == 0) begin
      transfer(CMD_QUERY, '0, 10'($urandom), 11'($urandom));
      return;
    end
    lo = $urandom_range(0, count - 1);
    if ($urandom_range(0, 1)) hi = $urandom_range(lo + 1, count);
    else hi = $urandom_range(lo + 1, (lo + 31 < count) ? lo + 31 : count);
    transfer(CMD_QUERY, '0, lo[9:0], hi[10:0]);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 7)) - 4;
      1: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  row_t directed[] = '{
    '{CMD_QUERY,  32'sd0, 10'd0, 11'd1, 1'b1, 10'd0, ST_BAD_RANGE},
    '{CMD_BUILD,  32'sd0, 10'd0, 11'd0, 1'b1, 10'd0, ST_OK},
    '{CMD_APPEND, 32'sh7fff_ffff, 10'd0, 11'd0, 1'b1, 10'd0, ST_OK},
    '{CMD_APPEND, 32'sh8000_0000, 10'd0, 11'd0, 1'b1, 10'd0, ST_OK},
    '{CMD_APPEND, 32'sh8000_0000, 10'd0, 11'd0, 1'b1, 10'd0, ST_OK},
    '{CMD_APPEND, -32'sd1, 10'd0, 11'd0, 1'b1, 10'd0, ST_OK},
    '{CMD_QUERY,  32'sd0, 10'd0, 11'd4, 1'b1, 10'd0, ST_NOT_BUILT},
    '{CMD_QUERY,  32'sd0, 10'd2, 11'd2, 1'b1, 10'd0, ST_BAD_RANGE},
    '{CMD_QUERY,  32'sd0, 10'd0, 11'd5, 1'b1, 10'd0, ST_BAD_RANGE},
    '{CMD_QUERY,  32'sd0, 10'd1023, 11'd1024, 1'b1, 10'd0, ST_BAD_RANGE},
    '{CMD_BUILD,  32'sd0, 10'd0, 11'd0, 1'b1, 10'd0, ST_OK},
    '{CMD_QUERY,  32'sd0, 10'd0, 11'd4, 1'b1, 10'd1, ST_OK},
    '{CMD_QUERY,  32'sd0, 10'd3, 11'd4, 1'b1, 10'd3, ST_OK},
    '{CMD_QUERY,  32'sd0, 10'd0, 11'd1, 1'b1, 10'd0, ST_OK},
    '{CMD_APPEND, 32'sd5, 10'd0, 11'd0, 1'b1, 10'd0, ST_OK},
    '{CMD_QUERY,  32'sd0, 10'd0, 11'd2, 1'b1, 10'd0, ST_NOT_BUILT},
    '{CMD_CLEAR,  32'sd0, 10'd0, 11'd0, 1'b1, 10'd0, ST_OK},
    '{CMD_QUERY,  32'sd0, 10'd0, 11'd1, 1'b1, 10'd0, ST_BAD_RANGE}
  };

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) begin
      transfer(directed[i].op, directed[i].val, directed[i].lo, directed[i].hi,
               directed[i].known, answer_t'{directed[i].idx, directed[i].st});
    end
    // fill part of the store, build, then query across blocks
    for (int i = 0; i < 400; i++) transfer(CMD_APPEND, rand_value(), '0, '0);
    transfer(CMD_BUILD, '0, '0, '0);
    transfer(CMD_QUERY, '0, 10'd0, 11'd400);
    transfer(CMD_QUERY, '0, 10'd399, 11'd400);
    for (int i = 0; i < 30; i++) random_query();
    drain();
    for (int n = 0; n < 300; n++) begin
      case ($urandom_range(0, 19))
        0: transfer(CMD_CLEAR, '0, '0, '0);
        1, 2: transfer(CMD_BUILD, '0, '0, '0);
        3, 4, 5, 6, 7, 8, 9: transfer(CMD_APPEND, rand_value(), '0, '0);
        default: random_query();
      endcase
      if (n == 150) drain();
    end
    drain();
    sender_done = 1;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 49) == 0) begin
        stall_left = $urandom_range(5, 30);
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0;
      end
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result idx=%0d st=%0d", min_pos, status);
      end else begin
        if (min_pos !== pending[0].idx || status !== pending[0].st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected idx=%0d st=%0d, got idx=%0d st=%0d",
                     pending[0].idx, pending[0].st, min_pos, status);
        end
        void'(pending.pop_front());
      end
    end
  end

  initial begin
    wait (sender_done && pending.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending.size() == 0) $display("[bitmask_block_range_min_query_unit] OK");
    else $display("[bitmask_block_range_min_query_unit] ERROR");
    $finish;
  end

  initial begin
    #100ms;
    $display("[bitmask_block_range_min_query_unit] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
hdl/bbrmq_pkg.sv
hdl/bitmask_block_range_min_query_unit.sv
tb/tb_bitmask_block_range_min_query_unit.sv
